// ===== design/rlee_pkg.sv =====
// shared types and constants of the radial log enrichment evaluator
// no dependencies; imported by every design and checker file but rlee_delay and rlee_div
`default_nettype none

package rlee_pkg;

	// fraction bits of the log2 mantissa search and ln(2) in Q31
	localparam int          LOG_FRAC = 24;
	localparam logic [30:0] LN2_Q31  = 31'd1488522236;

	// cycles of the front end (difference, magnitude, square, compare)
	localparam int FRONT_LAT = 4;
	// cycles of the log unit: top bit, normalize, squarings, multiply, round
	localparam int LOG_LAT   = LOG_FRAC + 4;

	typedef enum logic [1:0] {
		CFG_CENTER_X = 2'd0,
		CFG_CENTER_Y = 2'd1,
		CFG_RADIUS   = 2'd2
	} cfg_reg_e;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
	} point_t;

	typedef struct packed {
		logic signed [31:0] enrich_value;
		logic signed [31:0] grad_x;
		logic signed [31:0] grad_y;
		logic               inside_radius;
		logic               grad_saturated;
	} result_t;

	// front end to back end
	typedef struct packed {
		logic        valid;
		logic        in_well;
		logic [64:0] dist2;
		logic [64:0] log_arg;
		logic [31:0] mag_x;
		logic [31:0] mag_y;
		logic        neg_x;
		logic        neg_y;
	} front_t;

	// control that travels beside the log and divide units
	typedef struct packed {
		logic valid;
		logic in_well;
		logic neg_x;
		logic neg_y;
		logic zero_x;
		logic zero_y;
	} side_t;

	function automatic int rlee_max(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	function automatic int rlee_latency(input int frac_bits);
		return FRONT_LAT + rlee_max(LOG_LAT, 2 * frac_bits + 1) + 1;
	endfunction

endpackage

`default_nettype wire

// ===== design/radial_log_enrichment_eval.sv =====
// radial log enrichment evaluator: ln(max(d, r)) and (dx, dy)/d^2 in Q F
// latency set by the longer of the log pipeline and the quotient pipeline of
// the gradient dividers; one point accepted every cycle
// reset clears the pipeline valid bits and loads center 0, radius 1.0
// the receiver cannot stall: each result shows for one cycle under result_valid
`default_nettype none

module radial_log_enrichment_eval
	import rlee_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// point transaction
	input  wire logic        start,
	output logic             busy,
	input  wire point_t      point,
	// result transaction
	output logic             result_valid,
	output result_t          result,
	// configuration write transaction
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int QB  = 2 * FRAC_BITS + 1;
	localparam int DLY = rlee_max(LOG_LAT, QB);

	// configuration registers
	logic signed [31:0] center_x_q, center_y_q;
	logic        [30:0] radius_q;

	front_t        fo;
	side_t         side_in, side_out;
	logic [31:0]   log_raw, log_al;
	logic [QB-1:0] qx_raw, qy_raw, qx_al, qy_al;
	logic [31:0]   gx, gy;
	logic          sx, sy;
	result_t       result_q;
	logic          result_valid_q;

	// the pipeline never stalls, so points and writes are always taken
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			radius_q   <= 31'(1) << FRAC_BITS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CENTER_X: center_x_q <= cfg_data;
				CFG_CENTER_Y: center_y_q <= cfg_data;
				CFG_RADIUS:   radius_q   <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// differences, squares and radius clamp
	rlee_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.point    (point),
		.center_x (center_x_q),
		.center_y (center_y_q),
		.radius   (radius_q),
		.fo       (fo)
	);

	// value path
	rlee_log #(.FRAC_BITS(FRAC_BITS)) u_log (
		.clk   (clk),
		.arg   (fo.log_arg),
		.value (log_raw)
	);

	// gradient dividers, one per axis
	rlee_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
		.clk (clk),
		.mag (fo.mag_x),
		.den (fo.dist2),
		.quo (qx_raw)
	);

	rlee_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
		.clk (clk),
		.mag (fo.mag_y),
		.den (fo.dist2),
		.quo (qy_raw)
	);

	// line the shorter path up with the longer one
	rlee_delay #(.W(32), .N(DLY - LOG_LAT)) u_dly_log (
		.clk (clk), .arst_n (arst_n), .d (log_raw), .q (log_al)
	);

	rlee_delay #(.W(QB), .N(DLY - QB)) u_dly_qx (
		.clk (clk), .arst_n (arst_n), .d (qx_raw), .q (qx_al)
	);

	rlee_delay #(.W(QB), .N(DLY - QB)) u_dly_qy (
		.clk (clk), .arst_n (arst_n), .d (qy_raw), .q (qy_al)
	);

	always_comb begin
		side_in.valid   = fo.valid;
		side_in.in_well = fo.in_well;
		side_in.neg_x   = fo.neg_x;
		side_in.neg_y   = fo.neg_y;
		side_in.zero_x  = (fo.mag_x == 32'd0);
		side_in.zero_y  = (fo.mag_y == 32'd0);
	end

	// valid and flags ride beside the units
	rlee_delay #(.W($bits(side_t)), .N(DLY)) u_dly_side (
		.clk (clk), .arst_n (arst_n), .d (side_in), .q (side_out)
	);

	// signed, saturated gradient component from an unsigned quotient
	function automatic logic [32:0] grad_fix(input logic [QB-1:0] q, input logic neg,
		input logic zero);
		logic [63:0] qw;
		logic [31:0] v;
		logic        sat;
		qw  = 64'(q);
		v   = 32'd0;
		sat = 1'b0;
		if (!zero) begin
			if (!neg) begin
				if (qw > 64'h7FFF_FFFF) begin
					sat = 1'b1;
					v   = 32'h7FFF_FFFF;
				end else begin
					v = qw[31:0];
				end
			end else begin
				if (qw > 64'h8000_0000) begin
					sat = 1'b1;
					v   = 32'h8000_0000;
				end else begin
					v = 32'd0 - qw[31:0];
				end
			end
		end
		return {sat, v};
	endfunction

	assign {sx, gx} = grad_fix(qx_al, side_out.neg_x, side_out.zero_x);
	assign {sy, gy} = grad_fix(qy_al, side_out.neg_y, side_out.zero_y);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= side_out.valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q.enrich_value  <= log_al;
		result_q.inside_radius <= side_out.in_well;
		if (side_out.in_well) begin
			// on or inside the well: flat enrichment
			result_q.grad_x         <= '0;
			result_q.grad_y         <= '0;
			result_q.grad_saturated <= 1'b0;
		end else begin
			result_q.grad_x         <= gx;
			result_q.grad_y         <= gy;
			result_q.grad_saturated <= sx | sy;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// ===== design/rlee_delay.sv =====
// fixed-length register delay line with cleared reset
// no dependencies
`default_nettype none

module rlee_delay #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic [W-1:0] d,
	output logic      [W-1:0] q
);

	generate
		if (N == 0) begin : g_none
			assign q = d;
		end else begin : g_line
			logic [W-1:0] line_s [0:N-1];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					for (int i = 0; i < N; i++) line_s[i] <= '0;
				end else begin
					line_s[0] <= d;
					for (int i = 1; i < N; i++) line_s[i] <= line_s[i-1];
				end
			end

			assign q = line_s[N-1];
		end
	endgenerate

endmodule

`default_nettype wire

// ===== design/rlee_front.sv =====
// front end: center difference, magnitude, squares, radius compare
// depends on rlee_pkg
`default_nettype none

module rlee_front
	import rlee_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire point_t             point,
	input  wire logic signed [31:0] center_x,
	input  wire logic signed [31:0] center_y,
	input  wire logic        [30:0] radius,
	output front_t                  fo
);

	logic               valid_s1, valid_s2, valid_s3, valid_s4;
	logic signed [32:0] dx_s1, dy_s1;
	logic        [31:0] ax_s2, ay_s2, ax_s3, ay_s3, ax_s4, ay_s4;
	logic               nx_s2, ny_s2, nx_s3, ny_s3, nx_s4, ny_s4;
	logic        [30:0] r_s2;
	logic        [63:0] sx_s3, sy_s3;
	logic        [61:0] r2_s3;
	logic        [64:0] d_s4, m_s4;
	logic               in_s4;
	logic        [64:0] dsum;
	logic        [64:0] r2x;
	logic               in_well;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	assign dsum    = {1'b0, sx_s3} + {1'b0, sy_s3};
	assign r2x     = {3'b0, r2_s3};
	assign in_well = (dsum <= r2x);

	always_ff @(posedge clk) begin
		dx_s1 <= {point.point_x[31], point.point_x} - {center_x[31], center_x};
		dy_s1 <= {point.point_y[31], point.point_y} - {center_y[31], center_y};
		// magnitude of a 33-bit difference never exceeds 2^32-1
		ax_s2 <= dx_s1[32] ? 32'(-dx_s1) : dx_s1[31:0];
		ay_s2 <= dy_s1[32] ? 32'(-dy_s1) : dy_s1[31:0];
		nx_s2 <= dx_s1[32];
		ny_s2 <= dy_s1[32];
		// zero radius acts as one lsb
		r_s2  <= (radius == 31'd0) ? 31'd1 : radius;
		sx_s3 <= ax_s2 * ax_s2;
		sy_s3 <= ay_s2 * ay_s2;
		r2_s3 <= r_s2 * r_s2;
		ax_s3 <= ax_s2;
		ay_s3 <= ay_s2;
		nx_s3 <= nx_s2;
		ny_s3 <= ny_s2;
		d_s4  <= dsum;
		m_s4  <= in_well ? r2x : dsum;
		in_s4 <= in_well;
		ax_s4 <= ax_s3;
		ay_s4 <= ay_s3;
		nx_s4 <= nx_s3;
		ny_s4 <= ny_s3;
	end

	always_comb begin
		fo.valid   = valid_s4;
		fo.in_well = in_s4;
		fo.dist2   = d_s4;
		fo.log_arg = m_s4;
		fo.mag_x   = ax_s4;
		fo.mag_y   = ay_s4;
		fo.neg_x   = nx_s4;
		fo.neg_y   = ny_s4;
	end

endmodule

`default_nettype wire

// ===== design/rlee_log.sv =====
// pipelined half natural log of a 65-bit integer in Q(2F), result in Q F
// depends on rlee_pkg
`default_nettype none

module rlee_log
	import rlee_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic [64:0] arg,
	output logic      [31:0] value
);

	localparam logic signed [31:0] TWO_F_Q = 32'(2 * FRAC_BITS) <<< LOG_FRAC;
	localparam logic signed [63:0] RND     = 64'sd1 <<< (LOG_FRAC + 31 - FRAC_BITS);
	localparam int                 SH      = LOG_FRAC + 32 - FRAC_BITS;

	logic        [6:0]          p_s1, p_s2;
	logic        [64:0]         m_s1;
	logic        [31:0]         x_s2;
	logic        [64:0]         norm;
	logic        [6:0]          top;
	logic        [31:0]         sq_x_s [1:LOG_FRAC];
	logic        [LOG_FRAC-1:0] sq_f_s [1:LOG_FRAC];
	logic        [6:0]          sq_p_s [1:LOG_FRAC];
	logic signed [31:0]         t;
	logic signed [63:0]         prod_s27;
	logic signed [63:0]         rsum;
	logic        [31:0]         value_s28;

	// top set bit; the argument is never zero
	always_comb begin
		top = 7'd0;
		for (int i = 0; i < 65; i++) begin
			if (arg[i]) top = 7'(i);
		end
	end

	assign norm = m_s1 << (7'd64 - p_s1);

	always_ff @(posedge clk) begin
		p_s1 <= top;
		m_s1 <= arg;
		p_s2 <= p_s1;
		x_s2 <= norm[64:33];
	end

	// one fraction bit of log2 per stage by squaring the mantissa
	generate
		for (genvar k = 0; k < LOG_FRAC; k++) begin : g_sq
			logic [31:0]         xin;
			logic [LOG_FRAC-1:0] fin;
			logic [6:0]          pin;
			logic [63:0]         sq;
			if (k == 0) begin : g_first
				assign xin = x_s2;
				assign fin = '0;
				assign pin = p_s2;
			end else begin : g_next
				assign xin = sq_x_s[k];
				assign fin = sq_f_s[k];
				assign pin = sq_p_s[k];
			end
			assign sq = xin * xin;
			always_ff @(posedge clk) begin
				sq_x_s[k+1] <= sq[63] ? sq[63:32] : sq[62:31];
				sq_f_s[k+1] <= {fin[LOG_FRAC-2:0], sq[63]};
				sq_p_s[k+1] <= pin;
			end
		end
	endgenerate

	assign t = $signed({1'b0, sq_p_s[LOG_FRAC], {LOG_FRAC{1'b0}}})
		+ $signed({{(32 - LOG_FRAC){1'b0}}, sq_f_s[LOG_FRAC]}) - TWO_F_Q;

	assign rsum = prod_s27 + RND;

	always_ff @(posedge clk) begin
		prod_s27  <= t * $signed({1'b0, LN2_Q31});
		value_s28 <= 32'(rsum >>> SH);
	end

	assign value = value_s28;

endmodule

`default_nettype wire

// ===== design/rlee_div.sv =====
// pipelined restoring divider: (mag << 2F) / den, one quotient bit a stage
// no package dependency
`default_nettype none

module rlee_div #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic [31:0]            mag,
	input  wire logic [64:0]            den,
	output logic      [2*FRAC_BITS:0]   quo
);

	// den >= mag^2 bounds the quotient by 2^(2F)
	localparam int QB = 2 * FRAC_BITS + 1;

	logic [64:0]   rem_s [1:QB];
	logic [QB-1:0] q_s   [1:QB];
	logic [64:0]   den_s [1:QB];

	generate
		for (genvar k = 0; k < QB; k++) begin : g_step
			logic [64:0]   rin;
			logic [QB-1:0] qin;
			logic [64:0]   din;
			logic          nbit;
			logic [65:0]   trial;
			logic [65:0]   diff;
			logic          ge;
			if (k == 0) begin : g_first
				// numerator bits above the quotient form the first remainder
				assign rin  = 65'(mag >> 1);
				assign qin  = '0;
				assign din  = den;
				assign nbit = mag[0];
			end else begin : g_next
				assign rin  = rem_s[k];
				assign qin  = q_s[k];
				assign din  = den_s[k];
				assign nbit = 1'b0;
			end
			assign trial = {rin, nbit};
			assign diff  = trial - {1'b0, din};
			assign ge    = (trial >= {1'b0, din});
			always_ff @(posedge clk) begin
				rem_s[k+1] <= ge ? diff[64:0] : trial[64:0];
				q_s[k+1]   <= {qin[QB-2:0], ge};
				den_s[k+1] <= din;
			end
		end
	endgenerate

	assign quo = q_s[QB];

endmodule

`default_nettype wire

// ===== design/rlee_checker.sv =====
// port-level checks of the radial log enrichment evaluator, with its bind
// depends on rlee_pkg and radial_log_enrichment_eval
`default_nettype none

module rlee_props
	import rlee_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    start,
	input wire logic    busy,
	input wire logic    result_valid,
	input wire result_t result,
	input wire logic    cfg_valid,
	input wire logic    cfg_ready
);

	localparam int LAT = rlee_latency(FRAC_BITS);

	// each accepted point gives a result a fixed time later
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT result_valid)
		else $error("result missing after accepted point");

	// no result without a point accepted that long ago
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start && !busy, LAT))
		else $error("result without a matching point");

	a_inside_flat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.inside_radius |->
			result.grad_x == 32'sd0 && result.grad_y == 32'sd0 && !result.grad_saturated)
		else $error("gradient nonzero inside radius");

	a_sat_clip: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.grad_saturated |->
			result.grad_x == 32'h7FFF_FFFF || result.grad_x == 32'h8000_0000 ||
			result.grad_y == 32'h7FFF_FFFF || result.grad_y == 32'h8000_0000)
		else $error("saturation flag without clipped gradient");

	// configuration writes are never held off
	a_cfg_taken: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write held off");

endmodule

bind radial_log_enrichment_eval rlee_props #(.FRAC_BITS(FRAC_BITS)) u_rlee_props (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready)
);

`default_nettype wire

// ===== dv/rlee_checker.sv =====
// result checker for the radial log enrichment evaluator: predicts every point
// transaction and compares results in order; depends on rlee_pkg
`timescale 1ns / 1ps

module rlee_checker
	import rlee_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire point_t      point,
	input  wire logic        result_valid,
	input  wire result_t     result,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output int               errors,
	output int               pending
);

	logic signed [31:0] ctr_x, ctr_y;
	logic [30:0]        radius;
	result_t            expected_q[$];

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// ln(M)/2 in Q FRAC_BITS, M a Q(2F) 65-bit value
	function automatic logic [31:0] half_ln(input logic [64:0] m);
		int p;
		logic [63:0] x;
		logic [127:0] sq;
		logic [23:0] frac;
		longint t, prod;
		p = 0;
		frac = '0;
		if (m[64]) begin
			p = 64;
			x = {32'd0, 1'b1, m[63:33]};
		end else begin
			for (int i = 1; i < 64; i++)
				if (m[i]) p = i;
			x = (p >= 31) ? (m[63:0] >> (p - 31)) : (m[63:0] << (31 - p));
		end
		for (int i = 0; i < LOG_FRAC; i++) begin
			sq = x * x;
			x = sq[94:31];
			frac = frac << 1;
			if (x >= 64'h1_0000_0000) begin
				frac[0] = 1'b1;
				x = x >> 1;
			end
		end
		t = (longint'(p) <<< LOG_FRAC) + longint'(frac) - (longint'(2 * FRAC_BITS) <<< LOG_FRAC);
		prod = t * longint'(LN2_Q31);
		prod += longint'(1) <<< (LOG_FRAC + 31 - FRAC_BITS);
		prod = prod >>> (LOG_FRAC + 32 - FRAC_BITS);
		return prod[31:0];
	endfunction

	// dx/D with saturation; sets sat on clipping
	function automatic logic [31:0] grad_of(input logic signed [32:0] d, input logic [64:0] den,
		inout logic sat);
		logic [32:0] mag;
		logic [127:0] q;
		mag = d[32] ? -d : d;
		if (mag == 0) return 32'd0;
		q = ({95'd0, mag} << (2 * FRAC_BITS)) / {63'd0, den};
		if (!d[32]) begin
			if (q > 128'h7FFF_FFFF) begin sat = 1'b1; q = 128'h7FFF_FFFF; end
			return q[31:0];
		end
		if (q > 128'h8000_0000) begin sat = 1'b1; q = 128'h8000_0000; end
		return 32'd0 - q[31:0];
	endfunction

	function automatic result_t enrichment_of(input point_t pt);
		result_t r;
		logic signed [32:0] dx, dy;
		logic [32:0] ax, ay;
		logic [64:0] dist2, r2;
		logic [30:0] rad;
		logic sat;
		dx = 33'(pt.point_x) - 33'(ctr_x);
		dy = 33'(pt.point_y) - 33'(ctr_y);
		ax = dx[32] ? -dx : dx;
		ay = dy[32] ? -dy : dy;
		dist2 = 65'(ax) * 65'(ax) + 65'(ay) * 65'(ay);
		rad = (radius == 0) ? 31'd1 : radius;
		r2 = 65'(rad) * 65'(rad);
		sat = 1'b0;
		r.inside_radius = (dist2 <= r2);
		r.enrich_value = half_ln(r.inside_radius ? r2 : dist2);
		if (r.inside_radius) begin
			r.grad_x = '0;
			r.grad_y = '0;
		end else begin
			r.grad_x = grad_of(dx, dist2, sat);
			r.grad_y = grad_of(dy, dist2, sat);
		end
		r.grad_saturated = sat;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			ctr_x <= '0;
			ctr_y <= '0;
			radius <= 31'(1 << FRAC_BITS);
			expected_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (result_valid) begin
				if (expected_q.size() == 0) begin
					report("unexpected result", result.enrich_value, 32'd0);
				end else begin
					want = expected_q.pop_front();
					if (result.enrich_value !== want.enrich_value)
						report("enrich_value", result.enrich_value, want.enrich_value);
					if (result.grad_x !== want.grad_x)
						report("grad_x", result.grad_x, want.grad_x);
					if (result.grad_y !== want.grad_y)
						report("grad_y", result.grad_y, want.grad_y);
					if (result.inside_radius !== want.inside_radius)
						report("inside_radius", 32'(result.inside_radius), 32'(want.inside_radius));
					if (result.grad_saturated !== want.grad_saturated)
						report("grad_saturated", 32'(result.grad_saturated),
							32'(want.grad_saturated));
				end
			end
			if (start && !busy)
				expected_q.insert(expected_q.size(), enrichment_of(point));
			pending = expected_q.size();
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_e'(cfg_index))
					CFG_CENTER_X: ctr_x <= cfg_data;
					CFG_CENTER_Y: ctr_y <= cfg_data;
					CFG_RADIUS:   radius <= cfg_data[30:0];
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== dv/testbench.sv =====
// top of the radial log enrichment evaluator testbench: clock, reset, stimulus
// and verdict; depends on rlee_pkg, radial_log_enrichment_eval and rlee_checker
`timescale 1ns / 1ps

module testbench;
	import rlee_pkg::*;

	localparam int FRAC_BITS = 16;
	localparam int LATENCY   = rlee_latency(FRAC_BITS);
	localparam int LIMIT     = 400000;

	logic        clk, arst_n;
	logic        start, busy;
	point_t      point;
	logic        result_valid;
	result_t     result;
	logic        cfg_valid, cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	int          errors, pending;
	int          cycles;
	int          idle_pct;

	radial_log_enrichment_eval #(.FRAC_BITS(FRAC_BITS)) uut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .point(point),
		.result_valid(result_valid), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// checker sits beside the block and watches every channel
	rlee_checker #(.FRAC_BITS(FRAC_BITS)) enrich_check (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .point(point),
		.result_valid(result_valid), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog on total cycles
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	// one point transaction; start held until accepted, then lowered only if
	// the next call idles first or the caller lowers it
	task automatic send_point(input logic [31:0] px, input logic [31:0] py);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		point.point_x <= px;
		point.point_y <= py;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	// block drained: all results back, plus pipeline slack
	task automatic drain();
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// random coordinate: mostly near the center in a few scales, sometimes any
	function automatic logic [31:0] rand_coord(input logic [31:0] ctr);
		int sel;
		sel = $urandom_range(3);
		case (sel)
			0: return $urandom;
			1: return ctr + $urandom_range(131072) - 65536;
			2: return ctr + $urandom_range(2000) - 1000;
			default: return ctr + ($urandom & 32'h00FF_FFFF) - 32'h0080_0000;
		endcase
	endfunction

	task automatic random_phase(input int n, input logic [31:0] cx, input logic [31:0] cy);
		for (int i = 0; i < n; i++)
			send_point(rand_coord(cx), rand_coord(cy));
	endtask

	initial begin
		logic [31:0] cx, cy;
		start = 1'b0;
		point = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_CENTER_X;
		cfg_data = '0;
		idle_pct = 0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset config, extremes, on the radius, zero differences
		send_point(32'h0, 32'h0);
		send_point(32'h0001_0000, 32'h0);
		send_point(32'h0, 32'hFFFF_0000);
		send_point(32'h0001_0001, 32'h0);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_point(32'h8000_0000, 32'h8000_0000);
		send_point(32'h7FFF_FFFF, 32'h8000_0000);
		send_point(32'h0000_0000, 32'h0001_0002);
		send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drain();

		// extreme center with a tiny radius: saturating gradients near the center
		write_reg(CFG_CENTER_X, 32'h8000_0000);
		write_reg(CFG_CENTER_Y, 32'h7FFF_FFFF);
		write_reg(CFG_RADIUS, 32'd1);
		send_point(32'h8000_0000, 32'h7FFF_FFFF);
		send_point(32'h8000_0001, 32'h7FFF_FFFF);
		send_point(32'h8000_0002, 32'h7FFF_FFFE);
		send_point(32'h7FFF_FFFF, 32'h8000_0000);
		send_point(32'h8000_0000, 32'h7FFF_FFF0);
		drain();

		// zero radius acts as one lsb; then the largest radius
		write_reg(CFG_RADIUS, 32'd0);
		send_point(32'h8000_0000, 32'h7FFF_FFFF);
		send_point(32'h8000_0001, 32'h7FFF_FFFF);
		drain();
		write_reg(CFG_CENTER_X, 32'h0);
		write_reg(CFG_CENTER_Y, 32'h0);
		write_reg(CFG_RADIUS, 32'h7FFF_FFFF);
		send_point(32'h7FFF_FFFF, 32'h0);
		send_point(32'h8000_0000, 32'h0);
		send_point(32'h8000_0000, 32'h8000_0000);
		drain();

		// random phases over idling levels and settings
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: idle_pct = 0;
				1: idle_pct = 82;
				2: idle_pct = 0;
				3: idle_pct = 36;
				default: idle_pct = 82;
			endcase
			cx = (ph == 2) ? 32'h8000_0000 : $urandom;
			cy = (ph == 2) ? 32'h7FFF_FFFF : $urandom;
			write_reg(CFG_CENTER_X, cx);
			write_reg(CFG_CENTER_Y, cy);
			write_reg(CFG_RADIUS, (ph == 4) ? $urandom : 32'($urandom_range(200000)));
			random_phase(50, cx, cy);
			// sender holds off until every expected result is back
			start <= 1'b0;
			while (pending != 0) @(negedge clk);
			random_phase(50, cx, cy);
			drain();
		end

		if (errors == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
